// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every sampled edge
`define PFR_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PFR_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/pfr_pkg.sv =====
package pfr_pkg;

   // fade and ramp geometry
   localparam int FADE_TICKS     = 128;
   localparam int RAMP_ROWS      = 14;
   localparam int RAMP_COLUMNS   = 16;
   localparam int GREY_MID       = 128;
   localparam int SLOT_BASE      = 16;
   localparam int SET_COUNT      = 8;
   localparam int ENDPOINT_COUNT = 6;
   localparam int CHANNEL_COUNT  = 3;

   // field widths
   localparam int LEVEL_W     = 8;
   localparam int COUNT_W     = 8;
   localparam int SLOT_W      = 8;
   localparam int SET_W       = $clog2(SET_COUNT);
   localparam int FIELD_ROW_W = 4;
   localparam int FIELD_COL_W = 4;

   // column blend: |column*(end-start)| and its divide by RAMP_COLUMNS-1
   localparam int COL_DIV     = RAMP_COLUMNS - 1;
   localparam int SPAN_W      = FIELD_COL_W + LEVEL_W;
   localparam int SPAN_PROD_W = FIELD_COL_W + LEVEL_W + 2;
   localparam int COL_SHIFT   = SPAN_W + $clog2(COL_DIV);
   localparam int COL_MULT_W  = SPAN_W + 1;
   localparam int COL_MULT    = (2**COL_SHIFT + COL_DIV - 1) / COL_DIV;
   // blended level before fogging, signed
   localparam int RAMP_W      = SPAN_W + 2;

   // fog: (level-128)*(RAMP_ROWS-1-row) and its divide by RAMP_ROWS-1
   localparam int ROW_DIV     = RAMP_ROWS - 1;
   localparam int ROWM_W      = FIELD_ROW_W + 2;
   localparam int FOG_PROD_W  = RAMP_W + ROWM_W;
   // |level-128| stays below 2**13 and |weight| below 16
   localparam int FOG_W       = 16;
   localparam int ROW_SHIFT   = FOG_W + $clog2(ROW_DIV);
   localparam int ROW_MULT_W  = FOG_W + 1;
   localparam int ROW_MULT    = (2**ROW_SHIFT + ROW_DIV - 1) / ROW_DIV;
   localparam int OUT_W       = FOG_W + 2;

   // tick blend numerator
   localparam int BLEND_W = 2 * LEVEL_W;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_WORD_W = CSR_ADDR_W - 2;
   localparam logic [CSR_WORD_W-1:0] REG_FADE_ENABLE = '0;

   typedef logic [LEVEL_W-1:0] level_type;

   // endpoint order: start red, end red, start green, end green, start blue, end blue
   localparam level_type TARGET_SETS [SET_COUNT][ENDPOINT_COUNT] = '{
      '{8'd10, 8'd190, 8'd10, 8'd170, 8'd0,  8'd255},
      '{8'd10, 8'd190, 8'd10, 8'd170, 8'd0,  8'd128},
      '{8'd40, 8'd200, 8'd10, 8'd170, 8'd0,  8'd255},
      '{8'd0,  8'd128, 8'd40, 8'd128, 8'd40, 8'd192},
      '{8'd40, 8'd140, 8'd40, 8'd140, 8'd0,  8'd140},
      '{8'd20, 8'd100, 8'd50, 8'd150, 8'd60, 8'd255},
      '{8'd0,  8'd200, 8'd0,  8'd150, 8'd0,  8'd255},
      '{8'd80, 8'd140, 8'd80, 8'd140, 8'd80, 8'd140}
   };

   typedef struct packed {
      logic                   mode;
      logic [FIELD_ROW_W-1:0] ramp_row;
      logic [FIELD_COL_W-1:0] ramp_column;
   } req_type;

   typedef struct packed {
      level_type          red;
      level_type          green;
      level_type          blue;
      logic [SLOT_W-1:0]  palette_slot;
      level_type          start_red_out;
      level_type          end_red_out;
      level_type          start_green_out;
      level_type          end_green_out;
      level_type          start_blue_out;
      level_type          end_blue_out;
      logic [COUNT_W-1:0] fade_remaining;
      logic [SET_W-1:0]   target_set_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COL_DIV,
      ST_FOG,
      ST_TICK,
      ST_WRITE
   } ctrl_state_type;

   typedef struct packed {
      logic span;
      logic col_div;
      logic fog;
      logic tick;
      logic load_rsp;
   } dp_cmd_type;

endpackage

// ===== rtl/pfr_csr.sv =====
module pfr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pfr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pfr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pfr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic                           fade_enable
);
   import pfr_pkg::*;

   logic                  fade_enable_ff;
   logic                  fade_enable_in;
   logic [CSR_WORD_W-1:0] word_addr;
   logic                  hit;

   // word decode
   assign word_addr = csr_paddr[CSR_ADDR_W-1:2];
   assign hit       = (word_addr == REG_FADE_ENABLE);

   // write on the access phase
   always_comb begin
      fade_enable_in = fade_enable_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         fade_enable_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_enable_ff <= 1'b1;
      end else begin
         fade_enable_ff <= fade_enable_in;
      end
   end

   // read back
   assign csr_prdata  = (csr_psel && hit) ? CSR_DATA_W'(fade_enable_ff) : '0;
   assign csr_pready  = 1'b1;
   assign fade_enable = fade_enable_ff;

endmodule

// ===== rtl/pfr_ctrl.sv =====
`include "assert_macros.svh"

module pfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pfr_pkg::dp_cmd_type cmd
);
   import pfr_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           out_free;

   // output register can take a new result
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_mode ? ST_COL_DIV : ST_TICK;
            end
         end
         ST_COL_DIV: begin
            state_in = ST_FOG;
         end
         ST_FOG: begin
            state_in = ST_WRITE;
         end
         ST_TICK: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.span  = req_valid;
         end
         ST_COL_DIV: begin
            cmd.col_div = 1'b1;
         end
         ST_FOG: begin
            cmd.fog = 1'b1;
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
         end
         ST_WRITE: begin
            cmd.load_rsp = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // result valid
   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PFR_ASSERT_ALWAYS(a_cmd_onehot, clock, reset, ($onehot0({cmd.span, cmd.col_div, cmd.fog, cmd.tick, cmd.load_rsp})), "more than one datapath command")
   `PFR_ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load_rsp, rsp_valid_ff, "loaded result not shown")
   `PFR_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, (req_valid && !req_stall), (state_ff != ST_IDLE), "accepted request not started")

endmodule

// ===== rtl/pfr_datapath.sv =====
`include "assert_macros.svh"

module pfr_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pfr_pkg::req_type    req_data,
   input  pfr_pkg::dp_cmd_type cmd,
   input  logic                fade_enable,
   output pfr_pkg::rsp_type    rsp_data
);
   import pfr_pkg::*;

   // request fields
   logic                   mode_ff, mode_in;
   logic [FIELD_ROW_W-1:0] row_ff, row_in;
   logic [FIELD_COL_W-1:0] col_ff, col_in;

   // fade state
   logic [ENDPOINT_COUNT-1:0][LEVEL_W-1:0] ep_ff, ep_in;
   logic [ENDPOINT_COUNT-1:0][LEVEL_W-1:0] cap_ff, cap_in;
   logic [COUNT_W-1:0]                     count_ff, count_in;
   logic [SET_W-1:0]                       tgt_ff, tgt_in;

   // read pipeline registers
   logic [CHANNEL_COUNT-1:0][SPAN_W-1:0] span_mag_ff, span_mag_in;
   logic [CHANNEL_COUNT-1:0]             span_neg_ff, span_neg_in;
   logic [CHANNEL_COUNT-1:0][RAMP_W-1:0] ramp_ff, ramp_in;
   logic [CHANNEL_COUNT-1:0][FOG_W-1:0]  fog_mag_ff, fog_mag_in;
   logic [CHANNEL_COUNT-1:0]             fog_neg_ff, fog_neg_in;
   rsp_type                              rsp_ff, rsp_in;

   // lane results
   logic [CHANNEL_COUNT-1:0][SPAN_W-1:0]    span_mag_new;
   logic [CHANNEL_COUNT-1:0]                span_neg_new;
   logic [CHANNEL_COUNT-1:0][RAMP_W-1:0]    ramp_new;
   logic [CHANNEL_COUNT-1:0][FOG_W-1:0]     fog_mag_new;
   logic [CHANNEL_COUNT-1:0]                fog_neg_new;
   logic [CHANNEL_COUNT-1:0][LEVEL_W-1:0]   color;
   logic [ENDPOINT_COUNT-1:0][LEVEL_W-1:0]  blend_level;
   logic [COUNT_W-1:0]                      count_dec;
   logic signed [ROWM_W-1:0]                fog_weight;
   logic [SLOT_W-1:0]                       slot;

   assign count_dec  = count_ff - COUNT_W'(1);
   assign fog_weight = $signed(ROWM_W'(ROW_DIV)) - $signed(ROWM_W'(row_ff));
   assign slot       = SLOT_W'(SLOT_BASE + RAMP_COLUMNS * int'(row_ff) + int'(col_ff));

   // one lane per colour channel
   for (genvar ch = 0; ch < CHANNEL_COUNT; ch++) begin : g_lane
      logic signed [LEVEL_W:0]            diff;
      logic signed [SPAN_PROD_W-1:0]      span_prod;
      logic [SPAN_PROD_W-1:0]             span_abs;
      logic [SPAN_W+COL_MULT_W-1:0]       col_prod;
      logic [SPAN_W+COL_MULT_W-1:0]       col_shift;
      logic [SPAN_W-1:0]                  col_quot;
      logic signed [RAMP_W-1:0]           fog_base;
      logic signed [FOG_PROD_W-1:0]       fog_prod;
      logic [FOG_PROD_W-1:0]              fog_abs;
      logic [FOG_W+ROW_MULT_W-1:0]        row_prod;
      logic [FOG_W+ROW_MULT_W-1:0]        row_shift;
      logic [FOG_W-1:0]                   row_quot;
      logic [OUT_W-1:0]                   shade;

      // column times endpoint difference, kept as sign and magnitude
      assign diff = $signed({1'b0, ep_ff[2*ch+1]}) - $signed({1'b0, ep_ff[2*ch]});
      assign span_prod = SPAN_PROD_W'($signed({1'b0, req_data.ramp_column}))
                       * SPAN_PROD_W'(diff);
      assign span_abs  = span_prod[SPAN_PROD_W-1] ? SPAN_PROD_W'(-span_prod)
                                                  : SPAN_PROD_W'(span_prod);
      assign span_mag_new[ch] = span_abs[SPAN_W-1:0];
      assign span_neg_new[ch] = span_prod[SPAN_PROD_W-1];

      // divide by column count less one via reciprocal, truncating toward zero
      assign col_prod  = (SPAN_W+COL_MULT_W)'(span_mag_ff[ch])
                       * (SPAN_W+COL_MULT_W)'(COL_MULT);
      assign col_shift = col_prod >> COL_SHIFT;
      assign col_quot  = col_shift[SPAN_W-1:0];
      assign ramp_new[ch] = span_neg_ff[ch] ? RAMP_W'(ep_ff[2*ch]) - RAMP_W'(col_quot)
                                            : RAMP_W'(ep_ff[2*ch]) + RAMP_W'(col_quot);

      // distance from mid grey times row weight
      assign fog_base = $signed(ramp_ff[ch]) - $signed(RAMP_W'(GREY_MID));
      assign fog_prod = FOG_PROD_W'(fog_base) * FOG_PROD_W'(fog_weight);
      assign fog_abs  = fog_prod[FOG_PROD_W-1] ? FOG_PROD_W'(-fog_prod)
                                               : FOG_PROD_W'(fog_prod);
      assign fog_mag_new[ch] = fog_abs[FOG_W-1:0];
      assign fog_neg_new[ch] = fog_prod[FOG_PROD_W-1];

      // divide by row count less one, recentre and clamp
      assign row_prod  = (FOG_W+ROW_MULT_W)'(fog_mag_ff[ch])
                       * (FOG_W+ROW_MULT_W)'(ROW_MULT);
      assign row_shift = row_prod >> ROW_SHIFT;
      assign row_quot  = row_shift[FOG_W-1:0];
      assign shade = fog_neg_ff[ch] ? OUT_W'(GREY_MID) - OUT_W'(row_quot)
                                    : OUT_W'(GREY_MID) + OUT_W'(row_quot);
      assign color[ch] = shade[OUT_W-1]                ? '0 :
                         (|shade[OUT_W-2:LEVEL_W])     ? '1 :
                                                         shade[LEVEL_W-1:0];
   end

   // one lane per endpoint for the fade blend
   for (genvar k = 0; k < ENDPOINT_COUNT; k++) begin : g_blend
      logic [BLEND_W-1:0] blend;

      assign blend = BLEND_W'(count_dec) * BLEND_W'(cap_ff[k])
                   + (BLEND_W'(FADE_TICKS) - BLEND_W'(count_dec))
                   * BLEND_W'(TARGET_SETS[tgt_ff][k]);
      assign blend_level[k] = LEVEL_W'(blend / FADE_TICKS);
   end

   // next values
   always_comb begin
      mode_in     = mode_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      ep_in       = ep_ff;
      cap_in      = cap_ff;
      count_in    = count_ff;
      tgt_in      = tgt_ff;
      span_mag_in = span_mag_ff;
      span_neg_in = span_neg_ff;
      ramp_in     = ramp_ff;
      fog_mag_in  = fog_mag_ff;
      fog_neg_in  = fog_neg_ff;
      rsp_in      = rsp_ff;

      // take the request and form the column spans
      if (cmd.span) begin
         mode_in     = req_data.mode;
         row_in      = req_data.ramp_row;
         col_in      = req_data.ramp_column;
         span_mag_in = span_mag_new;
         span_neg_in = span_neg_new;
      end

      if (cmd.col_div) begin
         ramp_in = ramp_new;
      end

      if (cmd.fog) begin
         fog_mag_in = fog_mag_new;
         fog_neg_in = fog_neg_new;
      end

      // frame tick with fade enabled: blend step, or move on to the next target set
      if (cmd.tick && fade_enable) begin
         if (count_ff != '0) begin
            count_in = count_dec;
            ep_in    = blend_level;
         end else begin
            tgt_in   = tgt_ff + SET_W'(1);
            count_in = COUNT_W'(FADE_TICKS);
            cap_in   = ep_ff;
         end
      end

      // result register
      if (cmd.load_rsp) begin
         rsp_in.red             = mode_ff ? color[0] : '0;
         rsp_in.green           = mode_ff ? color[1] : '0;
         rsp_in.blue            = mode_ff ? color[2] : '0;
         rsp_in.palette_slot    = mode_ff ? slot : '0;
         rsp_in.start_red_out   = ep_ff[0];
         rsp_in.end_red_out     = ep_ff[1];
         rsp_in.start_green_out = ep_ff[2];
         rsp_in.end_green_out   = ep_ff[3];
         rsp_in.start_blue_out  = ep_ff[4];
         rsp_in.end_blue_out    = ep_ff[5];
         rsp_in.fade_remaining  = count_ff;
         rsp_in.target_set_out  = tgt_ff;
      end
   end

   // fade state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ENDPOINT_COUNT; k++) begin
            ep_ff[k] <= TARGET_SETS[0][k];
         end
         count_ff <= '0;
         tgt_ff   <= '0;
      end else begin
         ep_ff    <= ep_in;
         count_ff <= count_in;
         tgt_ff   <= tgt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      cap_ff      <= cap_in;
      span_mag_ff <= span_mag_in;
      span_neg_ff <= span_neg_in;
      ramp_ff     <= ramp_in;
      fog_mag_ff  <= fog_mag_in;
      fog_neg_ff  <= fog_neg_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_data = rsp_ff;

   `PFR_ASSERT_ALWAYS(a_count_bound, clock, reset, (count_ff <= COUNT_W'(FADE_TICKS)), "fade counter above fade length")
   `PFR_ASSERT_NEXT(a_read_keeps_endpoints, clock, reset, (cmd.col_div || cmd.fog), $stable(ep_ff), "palette read changed endpoints")
   `PFR_ASSERT_NEXT(a_tick_no_color, clock, reset, (cmd.load_rsp && !mode_ff), (rsp_ff.red == '0 && rsp_ff.green == '0 && rsp_ff.blue == '0 && rsp_ff.palette_slot == '0), "tick result carries a colour")

endmodule

// ===== rtl/palette_fade_ramp_engine_core.sv =====
// Palette fade ramp engine. Keeps six colour endpoints (start/end for red,
// green and blue) that fade over FADE_TICKS frame ticks toward eight built-in
// target sets, and computes fogged ramp entries on request. Requests are
// handled one at a time by a small sequencer. A palette read (mode 1) goes
// through the span, ramp and fog registers into the result register: the
// column span is formed as the request is accepted, then come the divide by
// the column count, the fog weighting, and the divide by the row count
// feeding the result register. A frame tick (mode 0) updates the fade state
// when the fade is enabled and then loads the result register, with all six
// endpoint blends done in parallel. The constant divides are reciprocal
// multiplies, one per cycle per channel. A finished result waits in an output
// register; the next request is taken as soon as the sequencer is back at
// idle, and a result still held in the output register stalls the sequencer
// at its last step. After reset the endpoints hold the first target set, the
// fade counter is zero and fade_enable (register 0, bit 0) is set; clearing
// it freezes the fade while reads still work.
module palette_fade_ramp_engine_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pfr_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pfr_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pfr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pfr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pfr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import pfr_pkg::*;

   dp_cmd_type cmd;
   logic       fade_enable;

   // configuration register
   pfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fade_enable (fade_enable)
   );

   // sequencer
   pfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // arithmetic and fade state
   pfr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .fade_enable (fade_enable),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== bench/palette_fade_ramp_engine_core_tb.sv =====
module palette_fade_ramp_engine_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfr_pkg::*;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_READ = 1'b1;
   localparam int   IDLE_LIMIT = 2000;
   localparam int   HOLD_CYCLES = 250;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // fade state mirrored by the bench
   level_type         fade_ends [ENDPOINT_COUNT];
   level_type         fade_origin [ENDPOINT_COUNT];
   logic [COUNT_W-1:0] ticks_left;
   logic [SET_W-1:0]  target_sel;
   logic              fade_on;

   rsp_type owed_ramp_results [$];
   int      mismatches = 0;
   bit      quiet = 1'b0;
   int      hold_request = 0;

   palette_fade_ramp_engine_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // fogged ramp channel, divisions truncate toward zero, clamped to a level
   function automatic int fog_level(input int s, input int e, input int row, input int col);
      int v;
      v = s + (col * (e - s)) / COL_DIV;
      v = ((v - GREY_MID) * (ROW_DIV - row)) / ROW_DIV + GREY_MID;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v;
   endfunction

   // advance the mirrored fade state by one request and build its response
   function automatic rsp_type fade_ramp_step(input req_type r);
      rsp_type o;
      int      c;
      o = '0;
      if (r.mode == MODE_TICK) begin
         if (fade_on) begin
            if (ticks_left != 0) begin
               ticks_left = ticks_left - COUNT_W'(1);
               c = int'(ticks_left);
               for (int k = 0; k < ENDPOINT_COUNT; k++) begin
                  fade_ends[k] = level_type'((c * int'(fade_origin[k])
                     + (FADE_TICKS - c) * int'(TARGET_SETS[target_sel][k])) / FADE_TICKS);
               end
            end else begin
               target_sel = target_sel + SET_W'(1);
               ticks_left = COUNT_W'(FADE_TICKS);
               for (int k = 0; k < ENDPOINT_COUNT; k++) fade_origin[k] = fade_ends[k];
            end
         end
      end else begin
         o.red = level_type'(fog_level(int'(fade_ends[0]), int'(fade_ends[1]),
            int'(r.ramp_row), int'(r.ramp_column)));
         o.green = level_type'(fog_level(int'(fade_ends[2]), int'(fade_ends[3]),
            int'(r.ramp_row), int'(r.ramp_column)));
         o.blue = level_type'(fog_level(int'(fade_ends[4]), int'(fade_ends[5]),
            int'(r.ramp_row), int'(r.ramp_column)));
         o.palette_slot = SLOT_W'(SLOT_BASE + int'(r.ramp_row) * RAMP_COLUMNS
            + int'(r.ramp_column));
      end
      o.start_red_out = fade_ends[0];
      o.end_red_out = fade_ends[1];
      o.start_green_out = fade_ends[2];
      o.end_green_out = fade_ends[3];
      o.start_blue_out = fade_ends[4];
      o.end_blue_out = fade_ends[5];
      o.fade_remaining = ticks_left;
      o.target_set_out = target_sel;
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_ramp_result(input rsp_type got);
      rsp_type want;
      if (owed_ramp_results.size() == 0) begin
         $error("response with no request outstanding");
         mismatches++;
         return;
      end
      want = owed_ramp_results.pop_front();
      check_field("red", want.red, got.red);
      check_field("green", want.green, got.green);
      check_field("blue", want.blue, got.blue);
      check_field("palette_slot", want.palette_slot, got.palette_slot);
      check_field("start_red_out", want.start_red_out, got.start_red_out);
      check_field("end_red_out", want.end_red_out, got.end_red_out);
      check_field("start_green_out", want.start_green_out, got.start_green_out);
      check_field("end_green_out", want.end_green_out, got.end_green_out);
      check_field("start_blue_out", want.start_blue_out, got.start_blue_out);
      check_field("end_blue_out", want.end_blue_out, got.end_blue_out);
      check_field("fade_remaining", want.fade_remaining, got.fade_remaining);
      check_field("target_set_out", 8'(want.target_set_out), 8'(got.target_set_out));
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send one request and record what it should produce
   task automatic send_request(input logic mode, input int row, input int col);
      req_type r;
      int      gap;
      r.mode = mode;
      r.ramp_row = FIELD_ROW_W'(row);
      r.ramp_column = FIELD_COL_W'(col);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      owed_ramp_results.push_back(fade_ramp_step(r));
   endtask

   task automatic send_tick();
      send_request(MODE_TICK, $urandom_range(0, 15), $urandom_range(0, 15));
   endtask

   // mostly rows inside the ramp, now and then past its last row
   task automatic send_random_read();
      int row;
      row = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 15) : $urandom_range(0, 13);
      send_request(MODE_READ, row, $urandom_range(0, 15));
   endtask

   // drop valid and hold until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (owed_ramp_results.size() != 0) @(posedge clock);
   endtask

   // write fade_enable, then read it back
   task automatic write_fade_enable(input logic value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_FADE_ENABLE, 2'b00};
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      fade_on = value;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("fade_enable", 8'(value), 8'(csr_prdata[0]));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // palette reads at the corners of the ramp and past its edges, from reset
   task automatic test_reset_reads();
      send_request(MODE_READ, 0, 0);
      send_request(MODE_READ, 0, 15);
      send_request(MODE_READ, 13, 0);
      send_request(MODE_READ, 13, 15);
      send_request(MODE_READ, 7, 8);
      send_request(MODE_READ, 14, 5);
      send_request(MODE_READ, 15, 15);
      send_request(MODE_READ, 10, 10);
   endtask

   // first tick starts a fade, later ticks blend toward the next set
   task automatic test_fade_start();
      send_request(MODE_TICK, 0, 0);
      send_request(MODE_TICK, 15, 15);
      send_request(MODE_TICK, 0, 0);
      send_request(MODE_READ, 5, 3);
   endtask

   // ticks freeze while disabled, reads still work
   task automatic test_fade_disabled();
      wait_drained();
      write_fade_enable(1'b0);
      send_request(MODE_TICK, 0, 0);
      send_request(MODE_TICK, 3, 9);
      send_request(MODE_READ, 13, 15);
      send_request(MODE_READ, 0, 1);
      wait_drained();
      write_fade_enable(1'b1);
   endtask

   // receiver holds off long enough that the block backs up its input
   task automatic test_back_pressure();
      wait_drained();
      hold_request = HOLD_CYCLES;
      repeat (6) send_request(($urandom_range(0, 1) == 0) ? MODE_TICK : MODE_READ,
                              $urandom_range(0, 13), $urandom_range(0, 15));
      wait_drained();
   endtask

   // run the fade across several ends of fade and target set changes
   task automatic test_target_wrap();
      int ticks;
      ticks = 0;
      while (ticks < 400) begin
         if ($urandom_range(0, 15) == 0) begin
            send_random_read();
         end else begin
            send_tick();
            ticks++;
         end
      end
      wait_drained();
   endtask

   // random ticks and reads in phases with fade_enable changed between them
   task automatic test_random_mix();
      logic enable;
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         quiet = (phase == 2);
         if (phase == 4) enable = 1'b0;
         else if (phase == 0) enable = 1'b1;
         else enable = ($urandom_range(0, 3) != 0);
         write_fade_enable(enable);
         for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 99) < 55) send_tick();
            else send_random_read();
         end
      end
      wait_drained();
      quiet = 1'b0;
      write_fade_enable(1'b1);
   endtask

   // response side: check each accepted response and drive random stalls
   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_valid && !rsp_stall) check_ramp_result(rsp_data);
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else if (hold_request > 0) begin
               stall_left = hold_request - 1;
               hold_request = 0;
               rsp_stall <= 1'b1;
            end else begin
               r = $urandom_range(0, 99);
               if (quiet || r < 70) begin
                  rsp_stall <= 1'b0;
               end else begin
                  rsp_stall <= 1'b1;
                  stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
               end
            end
         end
      end
   end

   // watchdog: too long with nothing accepted on either channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      for (int k = 0; k < ENDPOINT_COUNT; k++) begin
         fade_ends[k] = TARGET_SETS[0][k];
         fade_origin[k] = '0;
      end
      ticks_left = '0;
      target_sel = '0;
      fade_on = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_reads();
      test_fade_start();
      test_fade_disabled();
      test_back_pressure();
      test_target_wrap();
      test_random_mix();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
